// ===== hw/rtl/truncating_soft_float_alu_defines.svh =====
// assertion macros for the truncating soft float alu
`ifndef TRUNCATING_SOFT_FLOAT_ALU_DEFINES_SVH
`define TRUNCATING_SOFT_FLOAT_ALU_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define TSF_ASSERT_IMPL(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define TSF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define TSF_ASSERT_IMPL(lbl, clk, rst_n, prop, msg)
`define TSF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/tsfalu_pkg.sv =====
// shared types, codes and arithmetic helpers for the truncating soft float alu
package tsfalu_pkg;

    localparam int unsigned CyclesMax = 64;

    localparam logic [31:0] SignMask = 32'h8000_0000;
    localparam logic [31:0] ExpMask  = 32'h7F80_0000;
    localparam logic [31:0] MantMask = 32'h007F_FFFF;
    localparam logic [31:0] ExpOne   = 32'h0080_0000;
    localparam logic [31:0] ExpBias  = 32'h3F80_0000;
    localparam logic [31:0] MaxGap   = 32'h0B80_0000;

    typedef enum logic [2:0] {
        K_ADD  = 3'd0,
        K_SUB  = 3'd1,
        K_MUL  = 3'd2,
        K_I2F  = 3'd3,
        K_F2I  = 3'd4,
        K_POW  = 3'd5
    } t_kind;

    function automatic logic [5:0] lead_zeros(input logic [31:0] v);
        logic [5:0] n;
        logic       found;
        n = 6'd32;
        found = 1'b0;
        for (int i = 31; i >= 0; i--) begin
            if (!found && v[i]) begin
                n = 6'(31 - i);
                found = 1'b1;
            end
        end
        return n;
    endfunction

    function automatic logic [31:0] signed_mant(input logic [31:0] v);
        logic [31:0] m;
        m = ((v & MantMask) | ExpOne) << 1;
        return v[31] ? (32'd0 - m) : m;
    endfunction

endpackage

// ===== hw/rtl/truncating_soft_float_alu.sv =====
// truncating soft float alu: add, sub, mul, int/float conversion, power by squaring
// add, sub, int-to-float, float-to-int and unused kinds: accept, then S_ALU, then S_OUT with valid
// multiply: accept, then S_MULX, S_MULW and S_OUT; power: one square per exponent bit plus one
// multiply per set bit, each via S_POWS, S_MULX and S_MULW, so up to 64 multiplies; one shared 32x32 multiplier
// one transaction at a time: stall is high from accept until the result is taken
// reset: synchronous active low, clears the sequencer and output valid
`include "truncating_soft_float_alu_defines.svh"
module truncating_soft_float_alu (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_kind,
    input  logic [31:0] i_operand_a,
    input  logic [31:0] i_operand_b,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_result_bits
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_ALU   = 6'b000010,
        S_MULX  = 6'b000100,
        S_MULW  = 6'b001000,
        S_POWS  = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    t_state      r_state, n_state;
    logic [2:0]  r_kind;
    logic [31:0] r_a, r_b, r_acc, r_res, r_out;
    logic [31:0] n_a, n_b, n_acc, n_res, n_out;
    logic        r_pow_sq, n_pow_sq;      // power: current multiply is the squaring
    logic [31:0] r_ma, r_mb, n_ma, n_mb;  // multiply operands in flight
    logic [63:0] r_prod;

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = (r_state == S_OUT);
    assign o_result_bits = r_out;

    // --- shared multiplier: registered product of the aligned mantissas
    always_ff @(posedge i_clk) begin
        r_prod <= {32'd0, tsfalu_pkg::SignMask | {r_ma[22:0], 8'd0}}
                * {32'd0, tsfalu_pkg::SignMask | {r_mb[22:0], 8'd0}};
    end

    // --- multiply finish from registered product
    logic [31:0] mul_res;
    always_comb begin
        logic [31:0] sign, expa, expb, mana, manb, ex, hi, res, norm;
        sign = (r_ma ^ r_mb) & tsfalu_pkg::SignMask;
        expa = r_ma & tsfalu_pkg::ExpMask;
        expb = r_mb & tsfalu_pkg::ExpMask;
        mana = r_ma & tsfalu_pkg::MantMask;
        manb = r_mb & tsfalu_pkg::MantMask;
        ex   = expa + expb - tsfalu_pkg::ExpBias;
        hi   = r_prod[63:32];
        norm = {31'd0, hi[31]};
        if (mana != 32'd0 && manb != 32'd0) begin
            res = (((hi >> norm) >> 7) & tsfalu_pkg::MantMask) | ((norm << 23) + ex) | sign;
        end else if (expa == 32'd0 || expb == 32'd0) begin
            res = 32'd0;
        end else begin
            res = ex | mana | manb | sign;
        end
        if (((ex - tsfalu_pkg::ExpOne) & tsfalu_pkg::SignMask) != 32'd0) begin
            res = 32'd0;
        end
        mul_res = res;
    end

    // --- add, conversions
    logic [31:0] alu_res;
    always_comb begin
        logic [31:0] va, vb, expa, expb, ma, mb, ex, sum, sign, v, m, e;
        logic [5:0]  lz;
        logic [31:0] sh;
        va = r_a;
        vb = (r_kind == tsfalu_pkg::K_SUB) ? (r_b ^ tsfalu_pkg::SignMask) : r_b;
        expa = va & tsfalu_pkg::ExpMask;
        expb = vb & tsfalu_pkg::ExpMask;
        ma = tsfalu_pkg::signed_mant(va);
        mb = tsfalu_pkg::signed_mant(vb);
        ex = 32'd0; sum = 32'd0; sign = 32'd0; v = 32'd0; m = 32'd0; e = 32'd0;
        lz = 6'd0; sh = 32'd0;
        alu_res = 32'd0;
        case (r_kind) inside
            tsfalu_pkg::K_ADD, tsfalu_pkg::K_SUB: begin
                if (expa == 32'd0) begin
                    alu_res = vb;
                end else if (expb == 32'd0) begin
                    alu_res = va;
                end else if (expb > expa && (expb - expa) >= tsfalu_pkg::MaxGap) begin
                    alu_res = vb;
                end else if (expb <= expa && (expa - expb) >= tsfalu_pkg::MaxGap) begin
                    alu_res = va;
                end else begin
                    if (expb > expa) begin
                        ex = expb;
                        ma = $signed(ma) >>> ((expb - expa) >> 23);
                    end else begin
                        ex = expa;
                        mb = $signed(mb) >>> ((expa - expb) >> 23);
                    end
                    sum = ma + mb;
                    if (sum == 32'd0) begin
                        alu_res = 32'd0;
                    end else begin
                        sign = sum & tsfalu_pkg::SignMask;
                        if (sign != 32'd0) sum = 32'd0 - sum;
                        lz = tsfalu_pkg::lead_zeros(sum);
                        sh = 32'd8 - {26'd0, lz};
                        if (lz <= 6'd8) sum = sum >> (6'd8 - lz);
                        else sum = sum << (lz - 6'd8);
                        alu_res = (((sh - 32'd1) << 23) + ex)
                                | (sum & tsfalu_pkg::MantMask) | sign;
                    end
                end
            end
            tsfalu_pkg::K_I2F: begin
                v = r_a;
                if (v != 32'd0) begin
                    sign = v & tsfalu_pkg::SignMask;
                    if (sign != 32'd0) v = 32'd0 - v;
                    lz = tsfalu_pkg::lead_zeros(v);
                    if (lz >= 6'd8) v = v << (lz - 6'd8);
                    else v = v >> (6'd8 - lz);
                    alu_res = ((32'd158 - {26'd0, lz}) << 23)
                            | (v & tsfalu_pkg::MantMask) | sign;
                end
            end
            tsfalu_pkg::K_F2I: begin
                e = {24'd0, r_a[30:23]};
                if (e >= 32'd127) begin
                    m = (r_a & tsfalu_pkg::MantMask) | tsfalu_pkg::ExpOne;
                    if (e <= 32'd150) m = m >> (32'd150 - e);
                    else m = m << ((e - 32'd150) & 32'd31);
                    alu_res = r_a[31] ? (32'd0 - m) : m;
                end
            end
            default: alu_res = 32'd0;
        endcase
    end

    // --- sequencer
    always_comb begin
        n_state = r_state;
        n_a = r_a; n_b = r_b; n_acc = r_acc; n_res = r_res; n_out = r_out;
        n_pow_sq = r_pow_sq; n_ma = r_ma; n_mb = r_mb;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_a = i_operand_a;
                    n_b = i_operand_b;
                    n_ma = i_operand_a;
                    n_mb = i_operand_b;
                    if (i_kind == tsfalu_pkg::K_MUL) n_state = S_MULX;
                    else if (i_kind == tsfalu_pkg::K_POW) begin
                        n_acc = i_operand_a;
                        n_res = tsfalu_pkg::ExpBias;
                        n_state = S_POWS;
                    end else n_state = S_ALU;
                end
            end
            S_ALU: begin
                n_out = alu_res;
                n_state = S_OUT;
            end
            S_MULX: n_state = S_MULW;
            S_MULW: begin
                if (r_kind == tsfalu_pkg::K_MUL) begin
                    n_out = mul_res;
                    n_state = S_OUT;
                end else begin
                    if (r_pow_sq) begin
                        n_acc = mul_res;
                        n_b = r_b >> 1;
                    end else n_res = mul_res;
                    n_state = S_POWS;
                end
            end
            S_POWS: begin
                // pick next multiply: result*acc when the bit is set, then acc*acc; finish when b is zero
                if (r_b == 32'd0) begin
                    n_out = r_res;
                    n_state = S_OUT;
                end else if (r_b[0] && !r_pow_sq) begin
                    n_ma = r_res; n_mb = r_acc; n_pow_sq = 1'b1;
                    n_state = S_MULX;
                end else begin
                    n_ma = r_acc; n_mb = r_acc; n_pow_sq = 1'b1;
                    n_state = S_MULX;
                end
            end
            S_OUT: if (!i_stall) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
        // squaring flag: set means next multiply is the squaring step
        if (r_state == S_POWS && r_b != 32'd0) begin
            n_pow_sq = !(r_b[0] && !r_pow_sq);
        end
        if (r_state == S_MULW && r_kind == tsfalu_pkg::K_POW && r_pow_sq) n_pow_sq = 1'b0;
        if (r_state == S_MULW && r_kind == tsfalu_pkg::K_POW && !r_pow_sq) n_pow_sq = 1'b1;
        if (r_state == S_IDLE) n_pow_sq = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_kind  <= tsfalu_pkg::K_ADD;
            r_pow_sq <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pow_sq <= n_pow_sq;
            if (r_state == S_IDLE && i_valid) r_kind <= i_kind;
        end
        r_a <= n_a; r_b <= n_b; r_acc <= n_acc; r_res <= n_res; r_out <= n_out;
        r_ma <= n_ma; r_mb <= n_mb;
    end

    `TSF_ASSERT_IMPL(a_valid_state, i_clk, i_rst_n, o_valid == (r_state == S_OUT), "valid mismatch")
    `TSF_ASSERT_NEXT(a_mul_wait, i_clk, i_rst_n, r_state == S_MULX, r_state == S_MULW, "mul wait")
    `TSF_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_result_bits), "out hold")
    `TSF_ASSERT_NEXT(a_pow_done, i_clk, i_rst_n, r_state == S_POWS && r_b == 32'd0, o_valid && o_result_bits == $past(r_res), "pow done")

endmodule
